### src/pla_pkg.sv
`default_nettype none

package pla_pkg;

  // Fixed field widths of the command and result items.
  localparam int CFG_W   = 13;
  localparam int CMD_W   = 3;
  localparam int REQ_W   = 13;
  localparam int ID_W    = 15;
  localparam int OFF_W   = 12;
  localparam int STAT_W  = 2;
  localparam int STAMP_W = 16;

  // Default geometry of the pool.
  localparam int POOL_BYTES_DEF   = 4096;
  localparam int CELL_BYTES_DEF   = 4;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int MIN_SPLIT_DEF    = 32;

  // Reset value of the pool length register.
  localparam int POOL_LEN_RESET = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT     = 3'd0,
    CMD_FREE_ALL = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_FREE     = 3'd3,
    CMD_FIND     = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Headers always start on a multiple of the largest power of two, up to eight,
  // that divides both the cell size and the header size.
  function automatic int align_shift(input int c, input int h);
    int s;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if ((((c >> s) & 1) == 0) && (((h >> s) & 1) == 0)) begin
        s = s + 1;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### src/pool_allocator_lru_evict.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we                     cfg_wdata (pool size, 13 bit)
// in        in         in_valid / in_stall        cmd, req_size, block_id, block_offset
// out       out        out_valid / out_stall      status, data_offset
//
// Every command gives exactly one result. Init and free-all write the free block
// at once and go straight to the done state; from there the result moves into the
// output register once it is free, and the next transfer can follow from then on.
// Find and free visit each block header on the chain in turn, each visit being one
// read of the header memory followed by its evaluation. Allocate visits headers
// the same way on each scan, with a release walk for every eviction and a second
// chain walk when the stamp counter wraps. After reset the S_RST state writes the
// initial free block before a transfer is taken.
// A stalled result sits in the output register while the next command runs.

module pool_allocator_lru_evict #(
  parameter int POOL_BYTES   = pla_pkg::POOL_BYTES_DEF,
  parameter int CELL_BYTES   = pla_pkg::CELL_BYTES_DEF,
  parameter int HEADER_BYTES = pla_pkg::HEADER_BYTES_DEF,
  parameter int MIN_SPLIT    = pla_pkg::MIN_SPLIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [pla_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [pla_pkg::CMD_W-1:0]  cmd,
  input  wire logic [pla_pkg::REQ_W-1:0]  req_size,
  input  wire logic [pla_pkg::ID_W-1:0]   block_id,
  input  wire logic [pla_pkg::OFF_W-1:0]  block_offset,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [pla_pkg::STAT_W-1:0] status,
  output logic      [pla_pkg::OFF_W-1:0]  data_offset
);
  import pla_pkg::*;

  // Byte positions carry room for a position plus a header plus a size.
  localparam int LPOOL = $clog2(POOL_BYTES);
  localparam int PW    = ((LPOOL > REQ_W) ? LPOOL : REQ_W) + 2;
  localparam int SW    = $clog2(POOL_BYTES + 1);
  localparam int SHIFT = align_shift(CELL_BYTES, HEADER_BYTES);
  localparam int DEPTH = POOL_BYTES >> SHIFT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MINP  = HEADER_BYTES + CELL_BYTES;
  localparam int LRST  = (POOL_LEN_RESET < MINP) ? MINP :
                         ((POOL_LEN_RESET > POOL_BYTES) ? POOL_BYTES : POOL_LEN_RESET);

  localparam logic [PW-1:0] HDR_P   = PW'(HEADER_BYTES);
  localparam logic [PW-1:0] SPLIT_P = PW'(MIN_SPLIT + HEADER_BYTES);
  localparam logic [SW-1:0] HDR_S   = SW'(HEADER_BYTES);

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    id;
    logic               used;
    logic [SW-1:0]      size;
  } hdr_t;

  typedef enum logic [17:0] {
    S_RST   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_A_SZ  = 18'h00004,
    S_A_CHK = 18'h00008,
    S_A_EV  = 18'h00010,
    S_A_FIT = 18'h00020,
    S_A_WF  = 18'h00040,
    S_W_CHK = 18'h00080,
    S_W_EV  = 18'h00100,
    S_R_CHK = 18'h00200,
    S_R_EV  = 18'h00400,
    S_R_H   = 18'h00800,
    S_R_N   = 18'h01000,
    S_R_WH  = 18'h02000,
    S_R_WP  = 18'h04000,
    S_F_CHK = 18'h08000,
    S_F_EV  = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p, input hdr_t hd);
    return p + HDR_P + PW'(hd.size);
  endfunction

  function automatic logic [AW-1:0] idx(input logic [PW-1:0] p);
    return p[SHIFT +: AW];
  endfunction

  state_t              state, state_next;
  logic [PW-1:0]       pos, pos_next;
  logic [PW-1:0]       prev_pos, prev_pos_next;
  logic                prev_v, prev_v_next;
  hdr_t                prev_hdr, prev_hdr_next;
  logic [PW-1:0]       h, h_next;
  hdr_t                cur, cur_next;
  logic [PW-1:0]       victim, victim_next;
  logic                victim_v, victim_v_next;
  logic [STAMP_W:0]    minst, minst_next;
  logic [PW-1:0]       sz_r, sz_r_next;
  logic [ID_W-1:0]     id_r, id_r_next;
  logic                ret_evict, ret_evict_next;
  status_t             status_r, status_r_next;
  logic [OFF_W-1:0]    doff, doff_next;
  logic [PW-1:0]       pool_len, pool_len_next;
  logic [STAMP_W-1:0]  stamp_cnt, stamp_cnt_next;
  logic [CFG_W-1:0]    pool_cfg;

  logic                accept;
  logic                out_free;
  logic [PW-1:0]       sz;
  logic [PW-1:0]       ps;
  logic [PW-1:0]       ps_clamped;
  logic [PW-1:0]       nx;
  logic [STAMP_W-1:0]  sc1;

  // Header memory: one write and one registered read per cycle.
  hdr_t                mem [DEPTH];
  hdr_t                rdata;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  hdr_t                wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  pla_round #(
    .CELL_BYTES (CELL_BYTES),
    .PW         (PW)
  ) u_round (
    .clk      (clk),
    .ld       (accept),
    .req_size (req_size),
    .sz       (sz)
  );

  assign ps         = PW'(pool_cfg);
  assign ps_clamped = (ps < PW'(MINP)) ? PW'(MINP) :
                      ((ps > PW'(POOL_BYTES)) ? PW'(POOL_BYTES) : ps);
  assign nx         = nxt(h, rdata);
  assign sc1        = stamp_cnt + STAMP_W'(1);

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    prev_pos_next  = prev_pos;
    prev_v_next    = prev_v;
    prev_hdr_next  = prev_hdr;
    h_next         = h;
    cur_next       = cur;
    victim_next    = victim;
    victim_v_next  = victim_v;
    minst_next     = minst;
    sz_r_next      = sz_r;
    id_r_next      = id_r;
    ret_evict_next = ret_evict;
    status_r_next  = status_r;
    doff_next      = doff;
    pool_len_next  = pool_len;
    stamp_cnt_next = stamp_cnt;
    rd_addr        = idx(pos);
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    case (state)
      S_RST: begin
        // The whole pool starts out as one free block.
        wr_en        = 1'b1;
        wr_data.size = SW'(pool_len - HDR_P);
        state_next   = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          status_r_next = ST_OK;
          doff_next     = '0;
          id_r_next     = block_id;
          pos_next      = '0;
          prev_v_next   = 1'b0;
          state_next    = S_DONE;
          case (cmd_t'(cmd))
            CMD_INIT: begin
              pool_len_next  = ps_clamped;
              stamp_cnt_next = '0;
              wr_en          = 1'b1;
              wr_data.size   = SW'(ps_clamped - HDR_P);
            end
            CMD_FREE_ALL: begin
              wr_en        = 1'b1;
              wr_data.size = SW'(pool_len - HDR_P);
            end
            CMD_ALLOC: begin
              state_next = S_A_SZ;
            end
            CMD_FREE: begin
              if (PW'(block_offset) < HDR_P) begin
                status_r_next = ST_NOT_FOUND;
              end else begin
                h_next         = PW'(block_offset) - HDR_P;
                ret_evict_next = 1'b0;
                state_next     = S_R_CHK;
              end
            end
            CMD_FIND: begin
              state_next = S_F_CHK;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_A_SZ: begin
        sz_r_next = sz;
        if (sz + HDR_P > pool_len) begin
          status_r_next = ST_TOO_BIG;
          state_next    = S_DONE;
        end else begin
          pos_next      = '0;
          victim_v_next = 1'b0;
          minst_next    = {1'b1, {STAMP_W{1'b0}}};
          state_next    = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (pos < pool_len) begin
          state_next = S_A_EV;
        end else if (victim_v) begin
          h_next         = victim;
          ret_evict_next = 1'b1;
          pos_next       = '0;
          prev_v_next    = 1'b0;
          state_next     = S_R_CHK;
        end else begin
          status_r_next = ST_TOO_BIG;
          state_next    = S_DONE;
        end
      end

      S_A_EV: begin
        if (!rdata.used && (PW'(rdata.size) >= sz_r)) begin
          h_next     = pos;
          cur_next   = rdata;
          state_next = S_A_FIT;
        end else begin
          if (rdata.used && ({1'b0, rdata.stamp} < minst)) begin
            minst_next    = {1'b0, rdata.stamp};
            victim_next   = pos;
            victim_v_next = 1'b1;
          end
          pos_next   = nxt(pos, rdata);
          state_next = S_A_CHK;
        end
      end

      S_A_FIT: begin
        // Split off the tail as a new free block when enough is left over.
        if (PW'(cur.size) > sz_r + SPLIT_P) begin
          wr_en         = 1'b1;
          wr_addr       = idx(h + HDR_P + sz_r);
          wr_data.size  = SW'(PW'(cur.size) - sz_r - HDR_P);
          cur_next.size = SW'(sz_r);
        end
        state_next = S_A_WF;
      end

      S_A_WF: begin
        doff_next      = OFF_W'(h + HDR_P);
        wr_en          = 1'b1;
        wr_addr        = idx(h);
        wr_data        = cur;
        wr_data.used   = 1'b1;
        wr_data.id     = id_r;
        wr_data.stamp  = sc1;
        cur_next       = wr_data;
        if (sc1 == '0) begin
          cur_next.stamp = STAMP_W'(1);
          stamp_cnt_next = STAMP_W'(1);
          pos_next       = '0;
          state_next     = S_W_CHK;
        end else begin
          stamp_cnt_next = sc1;
          state_next     = S_DONE;
        end
      end

      S_W_CHK: begin
        if (pos < pool_len) begin
          state_next = S_W_EV;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = idx(h);
          wr_data    = cur;
          state_next = S_DONE;
        end
      end

      S_W_EV: begin
        wr_en         = 1'b1;
        wr_addr       = idx(pos);
        wr_data       = rdata;
        wr_data.stamp = '0;
        pos_next      = nxt(pos, rdata);
        state_next    = S_W_CHK;
      end

      S_R_CHK: begin
        if ((pos < pool_len) && (pos != h)) begin
          state_next = S_R_EV;
        end else if ((pos != h) || (h >= pool_len)) begin
          status_r_next = ret_evict ? ST_TOO_BIG : ST_NOT_FOUND;
          state_next    = S_DONE;
        end else begin
          rd_addr    = idx(h);
          state_next = S_R_H;
        end
      end

      S_R_EV: begin
        prev_pos_next = pos;
        prev_hdr_next = rdata;
        prev_v_next   = 1'b1;
        pos_next      = nxt(pos, rdata);
        state_next    = S_R_CHK;
      end

      S_R_H: begin
        cur_next      = rdata;
        cur_next.used = 1'b0;
        if (nx < pool_len) begin
          rd_addr    = idx(nx);
          state_next = S_R_N;
        end else begin
          state_next = S_R_WH;
        end
      end

      S_R_N: begin
        if (!rdata.used) begin
          cur_next.size = cur.size + rdata.size + HDR_S;
        end
        state_next = S_R_WH;
      end

      S_R_WH: begin
        wr_en   = 1'b1;
        wr_addr = idx(h);
        wr_data = cur;
        if (prev_v && !prev_hdr.used) begin
          state_next = S_R_WP;
        end else if (ret_evict) begin
          pos_next      = '0;
          victim_v_next = 1'b0;
          minst_next    = {1'b1, {STAMP_W{1'b0}}};
          state_next    = S_A_CHK;
        end else begin
          state_next = S_DONE;
        end
      end

      S_R_WP: begin
        wr_en        = 1'b1;
        wr_addr      = idx(prev_pos);
        wr_data      = prev_hdr;
        wr_data.size = prev_hdr.size + cur.size + HDR_S;
        if (ret_evict) begin
          pos_next      = '0;
          victim_v_next = 1'b0;
          minst_next    = {1'b1, {STAMP_W{1'b0}}};
          state_next    = S_A_CHK;
        end else begin
          state_next = S_DONE;
        end
      end

      S_F_CHK: begin
        if (pos < pool_len) begin
          state_next = S_F_EV;
        end else begin
          status_r_next = ST_NOT_FOUND;
          state_next    = S_DONE;
        end
      end

      S_F_EV: begin
        if (rdata.used && (rdata.id == id_r)) begin
          doff_next  = OFF_W'(pos + HDR_P);
          state_next = S_DONE;
        end else begin
          pos_next   = nxt(pos, rdata);
          state_next = S_F_CHK;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RST;
      pool_len  <= PW'(LRST);
      stamp_cnt <= '0;
      pool_cfg  <= CFG_W'(POOL_LEN_RESET);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pool_len  <= pool_len_next;
      stamp_cnt <= stamp_cnt_next;
      if (cfg_we) begin
        pool_cfg <= cfg_wdata;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    prev_pos  <= prev_pos_next;
    prev_v    <= prev_v_next;
    prev_hdr  <= prev_hdr_next;
    h         <= h_next;
    cur       <= cur_next;
    victim    <= victim_next;
    victim_v  <= victim_v_next;
    minst     <= minst_next;
    sz_r      <= sz_r_next;
    id_r      <= id_r_next;
    ret_evict <= ret_evict_next;
    status_r  <= status_r_next;
    doff      <= doff_next;
    if ((state == S_DONE) && out_free) begin
      status      <= status_r;
      data_offset <= doff;
    end
  end

  // A finished command moves into the output register and frees the block.
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> out_valid && (state == S_IDLE))
    else $error("finished result not moved to output");

  // After a placement the stamp counter never reads zero.
  a_stamp_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WF) |=> (stamp_cnt != '0))
    else $error("stamp counter zero after allocation");

  // Header evaluations only happen for positions inside the pool.
  a_walk_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_EV) || (state == S_F_EV) || (state == S_W_EV) || (state == S_R_EV)
    |-> (pos < pool_len))
    else $error("chain walk left the pool");

endmodule

`default_nettype wire

### src/pla_round.sv
`default_nettype none

module pla_round #(
  parameter int CELL_BYTES = pla_pkg::CELL_BYTES_DEF,
  parameter int PW         = pla_pkg::REQ_W + 2
) (
  input  wire logic                      clk,
  input  wire logic                      ld,
  input  wire logic [pla_pkg::REQ_W-1:0] req_size,
  output logic      [PW-1:0]             sz
);
  import pla_pkg::*;

  // The request is rounded up to whole cells: ceil(max(req,1) / CELL_BYTES)
  // is taken by a multiplication with the scaled reciprocal.
  localparam int XW    = REQ_W + 1;
  localparam int K     = XW + 3;
  localparam int RW    = K + 1;
  localparam int PRW   = XW + RW;
  localparam int RECIP = ((1 << K) + CELL_BYTES - 1) / CELL_BYTES;

  logic [XW-1:0]  x;
  logic [PRW-1:0] prod;
  logic [XW-1:0]  q;

  assign x    = ((req_size == '0) ? XW'(1) : XW'(req_size)) + XW'(CELL_BYTES - 1);
  assign prod = PRW'(x) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (ld) begin
      q <= XW'(prod >> K);
    end
  end

  assign sz = PW'(q) * PW'(CELL_BYTES);

endmodule

`default_nettype wire

### dv/pool_allocator_lru_evict_tb.sv
`timescale 1ns / 100ps

module pool_allocator_lru_evict_tb;
  import pla_pkg::*;

  localparam int HDR         = HEADER_BYTES_DEF;
  localparam int CELL        = CELL_BYTES_DEF;
  localparam int SPLIT_MIN   = MIN_SPLIT_DEF;
  localparam int POOL_MAX    = POOL_BYTES_DEF;
  localparam int SETTLE_CYC  = 6;
  localparam int TAIL_CYC    = 40;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  // Kinds of entries in the stimulus queue. Live entries pick their block
  // offset or identifier from the predicted pool when they are launched.
  typedef enum int {
    K_CMD, K_LIVE_FREE, K_LIVE_FIND, K_CFG, K_DRAIN, K_QUIET
  } entry_kind_t;

  typedef struct {
    entry_kind_t          kind;
    logic [CMD_W-1:0]     op;
    logic [REQ_W-1:0]     req;
    logic [ID_W-1:0]      id;
    logic [OFF_W-1:0]     off;
  } entry_t;

  typedef struct {
    logic [STAT_W-1:0] st;
    logic [OFF_W-1:0]  doff;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd = '0;
  logic [REQ_W-1:0]    req_size = '0;
  logic [ID_W-1:0]     block_id = '0;
  logic [OFF_W-1:0]    block_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [OFF_W-1:0]    data_offset;

  pool_allocator_lru_evict dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .cmd, .req_size, .block_id, .block_offset,
    .out_valid, .out_stall, .status, .data_offset
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor. Block headers are kept by their byte offset in the pool,
  // the same way the chain walks them.
  // ---------------------------------------------------------------------------
  int           hdr_size  [POOL_MAX];
  bit           hdr_used  [POOL_MAX];
  logic [14:0]  hdr_id    [POOL_MAX];
  logic [15:0]  hdr_stamp [POOL_MAX];
  int           pool_len;
  logic [15:0]  stamp_cnt;
  logic [12:0]  pool_cfg_reg;

  function automatic int next_hdr(int p);
    return p + HDR + hdr_size[p];
  endfunction

  function automatic int clamp_pool(int v);
    if (v < HDR + CELL) v = HDR + CELL;
    if (v > POOL_MAX) v = POOL_MAX;
    return v;
  endfunction

  function automatic void rebuild_pool();
    hdr_size[0]  = pool_len - HDR;
    hdr_used[0]  = 1'b0;
    hdr_id[0]    = '0;
    hdr_stamp[0] = '0;
  endfunction

  // Frees the block whose header sits at h and merges it with free neighbors.
  // The merge with the successor never reaches past the end of the pool.
  function automatic bit release_block(int h);
    int p, prv, n;
    p = 0;
    prv = -1;
    while (p < pool_len && p != h) begin
      prv = p;
      p = next_hdr(p);
    end
    if (p != h || h >= pool_len) return 1'b0;
    hdr_used[h] = 1'b0;
    n = next_hdr(h);
    if (n < pool_len && !hdr_used[n]) hdr_size[h] += hdr_size[n] + HDR;
    if (prv >= 0 && !hdr_used[prv]) hdr_size[prv] += hdr_size[h] + HDR;
    return 1'b1;
  endfunction

  function automatic result_t pool_command(logic [CMD_W-1:0] op, logic [REQ_W-1:0] req,
                                           logic [ID_W-1:0] id, logic [OFF_W-1:0] boff);
    result_t r;
    int sz, fit, pos, victim, minst, nb;
    r.st = ST_OK;
    r.doff = '0;
    case (op)
      CMD_INIT: begin
        pool_len = clamp_pool(int'(pool_cfg_reg));
        stamp_cnt = '0;
        rebuild_pool();
      end
      CMD_FREE_ALL: rebuild_pool();
      CMD_ALLOC: begin
        // A zero request counts as one byte; sizes round up to whole cells.
        sz = (req == 0) ? 1 : int'(req);
        if (sz % CELL != 0) sz += CELL - sz % CELL;
        fit = -1;
        if (sz + HDR > pool_len) begin
          r.st = ST_TOO_BIG;
        end else begin
          // First fit; otherwise evict the oldest stamp (first in chain on a
          // tie, 65535 included) and scan again.
          forever begin
            pos = 0;
            victim = -1;
            minst = 65536;
            while (pos < pool_len) begin
              if (!hdr_used[pos] && hdr_size[pos] >= sz) begin
                fit = pos;
                break;
              end
              if (hdr_used[pos] && int'(hdr_stamp[pos]) < minst) begin
                minst = int'(hdr_stamp[pos]);
                victim = pos;
              end
              pos = next_hdr(pos);
            end
            if (fit >= 0 || victim < 0) break;
            void'(release_block(victim));
          end
          if (fit < 0) begin
            r.st = ST_TOO_BIG;
          end else begin
            if (hdr_size[fit] > sz + SPLIT_MIN + HDR) begin
              nb = fit + HDR + sz;
              hdr_size[nb]  = hdr_size[fit] - sz - HDR;
              hdr_used[nb]  = 1'b0;
              hdr_id[nb]    = '0;
              hdr_stamp[nb] = '0;
              hdr_size[fit] = sz;
            end
            hdr_used[fit] = 1'b1;
            hdr_id[fit]   = id;
            stamp_cnt = stamp_cnt + 16'd1;
            // On wrap every stamp is cleared and counting restarts at one.
            if (stamp_cnt == 0) begin
              pos = 0;
              while (pos < pool_len) begin
                hdr_stamp[pos] = '0;
                pos = next_hdr(pos);
              end
              stamp_cnt = 16'd1;
            end
            hdr_stamp[fit] = stamp_cnt;
            r.doff = OFF_W'(fit + HDR);
          end
        end
      end
      CMD_FREE: begin
        if (boff < HDR || !release_block(int'(boff) - HDR)) r.st = ST_NOT_FOUND;
      end
      CMD_FIND: begin
        r.st = ST_NOT_FOUND;
        pos = 0;
        while (pos < pool_len) begin
          if (hdr_used[pos] && hdr_id[pos] == id) begin
            r.st = ST_OK;
            r.doff = OFF_W'(pos + HDR);
            break;
          end
          pos = next_hdr(pos);
        end
      end
      default: ;  // spare command codes are ignored
    endcase
    return r;
  endfunction

  // Header offsets of the used blocks, in chain order.
  function automatic void used_blocks(ref int list[$]);
    int p;
    list.delete();
    p = 0;
    while (p < pool_len) begin
      if (hdr_used[p]) list.push_back(p);
      p = next_hdr(p);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by driver, monitor and sequence.
  // ---------------------------------------------------------------------------
  entry_t   stim_q[$];
  result_t  pending_results[$];
  bit       quiet = 1'b0;
  int       errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_cfg = 0;
  int       cycles = 0;

  initial begin
    for (int i = 0; i < POOL_MAX; i++) begin
      hdr_size[i] = 0;
      hdr_used[i] = 1'b0;
      hdr_id[i] = '0;
      hdr_stamp[i] = '0;
    end
    pool_cfg_reg = CFG_W'(POOL_LEN_RESET);
    pool_len = clamp_pool(int'(pool_cfg_reg));
    stamp_cnt = '0;
    rebuild_pool();
  end

  // Driver. A transfer is launched from the head of the stimulus queue after
  // its drawn gap; config writes and drain points wait until every expected
  // result has come back and the settle count has run out.
  int gap_left = 0;
  int settle = 0;

  always @(posedge clk) begin
    bit     v;
    bit     we;
    entry_t e;
    int     live[$];
    v = in_valid;
    we = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(pool_command(cmd, req_size, block_id, block_offset));
        n_sent++;
        v = 1'b0;
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          e = stim_q[0];
          case (e.kind)
            K_CFG, K_DRAIN: begin
              if (pending_results.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE_CYC) begin
                settle++;
              end else begin
                settle = 0;
                void'(stim_q.pop_front());
                if (e.kind == K_CFG) begin
                  we = 1'b1;
                  cfg_wdata <= e.req;
                  pool_cfg_reg = e.req;
                  n_cfg++;
                end
              end
            end
            K_QUIET: begin
              quiet = e.req[0];
              void'(stim_q.pop_front());
            end
            default: begin
              void'(stim_q.pop_front());
              if (e.kind != K_CMD) begin
                used_blocks(live);
                if (live.size() > 0) begin
                  int h;
                  h = live[$urandom_range(0, live.size() - 1)];
                  e.off = OFF_W'(h + HDR);
                  e.id = hdr_id[h];
                end
              end
              cmd <= e.op;
              req_size <= e.req;
              block_id <= e.id;
              block_offset <= e.off;
              v = 1'b1;
              gap_left = quiet ? 0 : $urandom_range(0, 11);
            end
          endcase
        end
      end
    end
    cfg_we <= we;
    in_valid <= v;
  end

  // Monitor. Each result transfer is checked against the oldest prediction;
  // the stall drawn after every transfer covers all phases of the block.
  int stall_left = 0;

  always @(posedge clk) begin
    result_t x;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] unexpected result: status %0d offset %0d", $realtime,
                     status, data_offset);
        end else begin
          x = pending_results.pop_front();
          n_checked++;
          if (status !== x.st || data_offset !== x.doff) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("[%0t] result %0d: expected status %0d offset %0d, got %0d %0d",
                       $realtime, n_checked, x.st, x.doff, status, data_offset);
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  function automatic void put(entry_kind_t k, logic [CMD_W-1:0] op, int req, int id,
                              int off);
    entry_t e;
    e.kind = k;
    e.op = op;
    e.req = REQ_W'(req);
    e.id = ID_W'(id);
    e.off = OFF_W'(off);
    stim_q.push_back(e);
  endfunction

  function automatic void new_pool(int bytes);
    put(K_CFG, CMD_INIT, bytes, 0, 0);
    put(K_CMD, CMD_INIT, $urandom_range(0, 8191), $urandom_range(0, 32767),
        $urandom_range(0, 4095));
  endfunction

  // One random transfer. Requests are mostly small against the pool so that
  // chains grow long, with occasional huge ones and full-width noise.
  function automatic void random_item(int bytes);
    int r, req, id;
    r = $urandom_range(0, 99);
    req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                      : $urandom_range(0, bytes / 3 + 1);
    id = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 32767);
    if (r < 45)      put(K_CMD, CMD_ALLOC, req, id, $urandom_range(0, 4095));
    else if (r < 65) put(K_LIVE_FREE, CMD_FREE, req, id, $urandom_range(0, 4095));
    else if (r < 70) put(K_CMD, CMD_FREE, req, id, $urandom_range(0, 4095));
    else if (r < 82) put(K_LIVE_FIND, CMD_FIND, req, id, 0);
    else if (r < 90) put(K_CMD, CMD_FIND, req, id, 0);
    else if (r < 94) put(K_CMD, CMD_FREE_ALL, req, id, $urandom_range(0, 4095));
    else if (r < 96) put(K_CMD, CMD_INIT, req, id, 0);
    else             put(K_CMD, CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                         req, id, 0);
  endfunction

  initial begin
    int sizes[$];
    int bytes;

    // Directed part: clamp at both ends, zero and oversized requests,
    // eviction, find hits and misses, bad and repeated frees, spare codes.
    new_pool(0);                                   // clamps to the smallest pool
    put(K_CMD, CMD_ALLOC, 0, 32767, 0);
    put(K_CMD, CMD_ALLOC, 5, 1, 0);
    new_pool(8191);                                // clamps to the full pool
    put(K_CMD, CMD_ALLOC, 1, 32767, 0);
    put(K_CMD, CMD_ALLOC, 4088, 2, 0);             // evicts the first block
    put(K_CMD, CMD_ALLOC, 8191, 3, 4095);
    put(K_CMD, CMD_ALLOC, 4096, 3, 0);
    put(K_CMD, CMD_FREE_ALL, 0, 0, 0);
    put(K_CMD, CMD_ALLOC, 100, 7, 0);
    put(K_CMD, CMD_ALLOC, 100, 7, 0);              // duplicate identifier
    put(K_CMD, CMD_FIND, 0, 7, 0);
    put(K_CMD, CMD_FIND, 0, 32767, 0);
    put(K_CMD, CMD_FREE, 0, 0, 0);                 // offset below one header
    put(K_CMD, CMD_FREE, 0, 0, 4095);
    put(K_CMD, CMD_FREE, 0, 0, 8);
    put(K_CMD, CMD_FREE, 0, 0, 8);                 // already free
    put(K_CMD, CMD_FREE, 0, 0, 116);               // merges both ways
    put(K_CMD, CMD_FREE_ALL, 0, 0, 0);
    put(K_CMD, CMD_SPARE_LO, 8191, 32767, 4095);
    put(K_CMD, CMD_SPARE_MID, 0, 0, 0);
    put(K_CMD, CMD_SPARE_HI, 0, 0, 0);

    // Random phases over several pool sizes, mostly small ones.
    sizes = '{4096, 16, 12, 64, 200, 333, 512, 96, 8191, 160};
    foreach (sizes[p]) begin
      bytes = clamp_pool(sizes[p]);
      put(K_QUIET, CMD_INIT, (p == 3), 0, 0);
      new_pool(sizes[p]);
      for (int i = 0; i < 115; i++) begin
        random_item(bytes);
        if (p == 4 && i == 60) put(K_DRAIN, CMD_INIT, 0, 0, 0);
      end
    end
    put(K_QUIET, CMD_INIT, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (stim_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Covered %0d command transfers and %0d checked results over %0d pool sizes,",
             n_sent, n_checked, n_cfg);
    $display("including evictions, merges, clamped sizes and a full drain.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/pla_pkg.sv
src/pla_round.sv
src/pool_allocator_lru_evict.sv
dv/pool_allocator_lru_evict_tb.sv
